### hw/rtl/printable_run_extractor_core_macros.svh
// ----------------------------------------------------------------------------
// printable run extractor assertion macros
// shared concurrent assertion shorthands for the extractor rtl
// ----------------------------------------------------------------------------
`ifndef PRINTABLE_RUN_EXTRACTOR_CORE_MACROS_SVH
`define PRINTABLE_RUN_EXTRACTOR_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PRX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define PRX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/prx_pkg.sv
// ----------------------------------------------------------------------------
// prx_pkg
// constants, codes, types and helpers of the printable run extractor
// ----------------------------------------------------------------------------
package prx_pkg;

    localparam int MAX_MIN_LEN = 32;
    localparam int HOLD_AW     = $clog2(MAX_MIN_LEN);
    localparam int CNT_W       = $clog2(MAX_MIN_LEN + 1);
    localparam int OFF_W       = 40;
    localparam int CHAR_W      = 8;
    localparam int MIN_LEN_W   = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = MIN_LEN_W'(4);

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LEN  = 2'd0,
        CFG_XPG_MODE = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic               en;
        logic [HOLD_AW-1:0] addr;
        logic [CHAR_W-1:0]  data;
    } hold_wr_t;

    function automatic logic is_printable(input logic [CHAR_W-1:0] b);
        return ((b >= CH_SPACE) && (b <= CH_TILDE)) || (b == CH_TAB);
    endfunction

    // min_len clamped to 1..MAX_MIN_LEN
    function automatic logic [CNT_W-1:0] eff_len(input logic [MIN_LEN_W-1:0] m);
        logic [CNT_W-1:0] r;
        if (m == '0)
            r = CNT_W'(1);
        else if (m > MIN_LEN_W'(MAX_MIN_LEN))
            r = CNT_W'(MAX_MIN_LEN);
        else
            r = CNT_W'(m);
        return r;
    endfunction

endpackage

### hw/rtl/prx_if.sv
// ----------------------------------------------------------------------------
// prx channel interfaces
// byte input, string output and configuration write channels
// ----------------------------------------------------------------------------
interface prx_byte_if;
    import prx_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic [CHAR_W-1:0]  data_byte;
    logic [OFF_W-1:0]   byte_offset;

    modport source (output valid, func, data_byte, byte_offset, input ready);
    modport sink   (input valid, func, data_byte, byte_offset, output ready);
endinterface

interface prx_str_if;
    import prx_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  char_out;
    logic [OFF_W-1:0]   start_offset;
    logic               first_char;
    logic               end_marker;
    logic               keep;
    logic               last_result;

    modport source (output valid, char_out, start_offset, first_char, end_marker, keep,
                    last_result, input ready);
    modport sink   (input valid, char_out, start_offset, first_char, end_marker, keep,
                    last_result, output ready);
endinterface

interface prx_cfg_if;
    import prx_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/printable_run_extractor_core.sv
// output: a result is registered from its byte transaction and is valid in the next cycle
// throughput: one byte per cycle unless stalled; the byte that completes min_len emits the
//   held run, one character per free output cycle from the held-byte file, stalling input
// reset: run state, phase and output valid clear; min_len resets to 4, xpg_mode to 0;
//   held bytes are not cleared
// ----------------------------------------------------------------------------
// printable_run_extractor_core
// scans a byte stream for printable runs and reports those reaching min_len
// ----------------------------------------------------------------------------
`include "printable_run_extractor_core_macros.svh"

module printable_run_extractor_core
    import prx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    prx_byte_if.sink    byte_ch,
    prx_str_if.source   str_ch,
    prx_cfg_if.sink     cfg
);

    // configuration
    logic [MIN_LEN_W-1:0] min_len_reg;
    logic                 xpg_mode_reg;

    // run state
    logic                 emitting_reg, emitting_next;
    logic [CNT_W-1:0]     run_count_reg, run_count_next;
    logic [OFF_W-1:0]     run_start_reg, run_start_next;

    // flush sequencer
    logic                 flush_active_reg, flush_active_next;
    logic [HOLD_AW-1:0]   flush_idx_reg, flush_idx_next;
    logic [HOLD_AW-1:0]   flush_last_reg, flush_last_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic [OFF_W-1:0]     start_reg, start_next;
    logic                 first_reg, first_next;
    logic                 end_reg, end_next;
    logic                 keep_reg, keep_next;
    logic                 last_reg, last_next;
    logic                 out_load;

    logic                 out_free;
    logic                 in_fire;
    logic                 cfg_fire;
    logic                 printable;
    logic [CNT_W-1:0]     cnt_new;
    logic [OFF_W-1:0]     start_sel;
    hold_wr_t             hold_wr;
    logic [HOLD_AW-1:0]   hold_rd_addr;
    logic [CHAR_W-1:0]    hold_rd_data;

    prx_held_buf u_held_buf (
        .clk     (clk),
        .wr      (hold_wr),
        .rd_addr (hold_rd_addr),
        .rd_data (hold_rd_data)
    );

    assign out_free      = !out_valid_reg || str_ch.ready;
    assign byte_ch.ready = !flush_active_reg && out_free;
    assign in_fire       = byte_ch.valid && byte_ch.ready;
    assign cfg.ready     = 1'b1;
    assign cfg_fire      = cfg.valid && cfg.ready;
    assign printable     = is_printable(byte_ch.data_byte);
    assign hold_rd_addr  = flush_active_reg ? flush_idx_reg : '0;

    always_comb
    begin
        emitting_next     = emitting_reg;
        run_count_next    = run_count_reg;
        run_start_next    = run_start_reg;
        flush_active_next = flush_active_reg;
        flush_idx_next    = flush_idx_reg;
        flush_last_next   = flush_last_reg;
        out_load          = 1'b0;
        char_next         = char_reg;
        start_next        = start_reg;
        first_next        = first_reg;
        end_next          = end_reg;
        keep_next         = keep_reg;
        last_next         = last_reg;
        hold_wr.en        = 1'b0;
        hold_wr.addr      = run_count_reg[HOLD_AW-1:0];
        hold_wr.data      = byte_ch.data_byte;
        cnt_new           = run_count_reg;
        start_sel         = (run_count_reg == '0) ? byte_ch.byte_offset : run_start_reg;

        if (flush_active_reg)
        begin
            // burst out the rest of the held run
            if (out_free)
            begin
                out_load   = 1'b1;
                char_next  = hold_rd_data;
                start_next = run_start_reg;
                first_next = 1'b0;
                end_next   = 1'b0;
                keep_next  = 1'b0;
                last_next  = (flush_idx_reg == flush_last_reg);
                flush_idx_next = flush_idx_reg + HOLD_AW'(1);
                if (flush_idx_reg == flush_last_reg)
                begin
                    flush_active_next = 1'b0;
                end
            end
        end
        else if (in_fire)
        begin
            if (byte_ch.func == FUNC_END)
            begin
                if (emitting_reg)
                begin
                    out_load   = 1'b1;
                    char_next  = '0;
                    start_next = run_start_reg;
                    first_next = 1'b0;
                    end_next   = 1'b1;
                    keep_next  = 1'b1;
                    last_next  = 1'b1;
                end
                emitting_next  = 1'b0;
                run_count_next = '0;
            end
            else if (emitting_reg)
            begin
                out_load   = 1'b1;
                start_next = run_start_reg;
                first_next = 1'b0;
                last_next  = 1'b1;
                if (printable)
                begin
                    char_next = byte_ch.data_byte;
                    end_next  = 1'b0;
                    keep_next = 1'b0;
                end
                else
                begin
                    char_next = '0;
                    end_next  = 1'b1;
                    keep_next = xpg_mode_reg ?
                        ((byte_ch.data_byte == CH_NL) || (byte_ch.data_byte == CH_NUL)) : 1'b1;
                    emitting_next  = 1'b0;
                    run_count_next = '0;
                end
            end
            else if (!printable)
            begin
                // short run dropped, newline included
                run_count_next = '0;
            end
            else
            begin
                run_start_next = start_sel;
                if (run_count_reg < CNT_W'(MAX_MIN_LEN))
                begin
                    hold_wr.en = 1'b1;
                    cnt_new    = run_count_reg + CNT_W'(1);
                end
                run_count_next = cnt_new;
                if (cnt_new >= eff_len(min_len_reg))
                begin
                    // first held char goes out now, the rest through the sequencer
                    out_load      = 1'b1;
                    char_next     = (run_count_reg == '0) ? byte_ch.data_byte : hold_rd_data;
                    start_next    = start_sel;
                    first_next    = 1'b1;
                    end_next      = 1'b0;
                    keep_next     = 1'b0;
                    last_next     = (cnt_new == CNT_W'(1));
                    emitting_next = 1'b1;
                    if (cnt_new != CNT_W'(1))
                    begin
                        flush_active_next = 1'b1;
                        flush_idx_next    = HOLD_AW'(1);
                        flush_last_next   = HOLD_AW'(cnt_new - CNT_W'(1));
                    end
                end
            end
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (str_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg      <= MIN_LEN_RST;
            xpg_mode_reg     <= 1'b0;
            emitting_reg     <= 1'b0;
            run_count_reg    <= '0;
            run_start_reg    <= '0;
            flush_active_reg <= 1'b0;
            flush_idx_reg    <= '0;
            flush_last_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg.index)
                    CFG_MIN_LEN:  min_len_reg  <= cfg.data[MIN_LEN_W-1:0];
                    CFG_XPG_MODE: xpg_mode_reg <= cfg.data[0];
                    default:      ;
                endcase
            end
            emitting_reg     <= emitting_next;
            run_count_reg    <= run_count_next;
            run_start_reg    <= run_start_next;
            flush_active_reg <= flush_active_next;
            flush_idx_reg    <= flush_idx_next;
            flush_last_reg   <= flush_last_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        start_reg <= start_next;
        first_reg <= first_next;
        end_reg   <= end_next;
        keep_reg  <= keep_next;
        last_reg  <= last_next;
    end

    assign str_ch.valid        = out_valid_reg;
    assign str_ch.char_out     = char_reg;
    assign str_ch.start_offset = start_reg;
    assign str_ch.first_char   = first_reg;
    assign str_ch.end_marker   = end_reg;
    assign str_ch.keep         = keep_reg;
    assign str_ch.last_result  = last_reg;

    `PRX_ASSERT_IMP(a_flush_in_emit, clk, rst_n, flush_active_reg, emitting_reg,
        "flush running outside emitting phase")
    `PRX_ASSERT_IMP(a_flush_idx_range, clk, rst_n, flush_active_reg,
        (flush_idx_reg != '0) && (flush_idx_reg <= flush_last_reg),
        "flush index out of range")
    `PRX_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1,
        run_count_reg <= CNT_W'(MAX_MIN_LEN), "run count above maximum")
    `PRX_ASSERT_NEXT(a_end_clears, clk, rst_n, in_fire && (byte_ch.func == FUNC_END),
        !emitting_reg && (run_count_reg == '0), "end of region left a run open")

endmodule

### hw/rtl/prx_held_buf.sv
// ----------------------------------------------------------------------------
// prx_held_buf
// register file holding the bytes of a run until it reaches min_len
// ----------------------------------------------------------------------------
module prx_held_buf
    import prx_pkg::*;
(
    input  logic               clk,
    input  hold_wr_t           wr,
    input  logic [HOLD_AW-1:0] rd_addr,
    output logic [CHAR_W-1:0]  rd_data
);

    logic [CHAR_W-1:0] held_reg [MAX_MIN_LEN];

    // no reset: only entries written in the current run are read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            held_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = held_reg[rd_addr];

endmodule
